FILE: rtl/uvs_pkg.sv
// Shared types, constants and fixed-point helpers for the UV sphere vertex generator.
package uvs_pkg;

   // Output coordinate format: Q2.14
   localparam int COORD_FRAC_BITS = 14;
   localparam logic [8:0] MAX_PRECISION = 9'd256;
   localparam logic [8:0] PREC_RESET = 9'd48;

   localparam int IDX_W = 17;
   localparam int DEN_W = 10;
   localparam int TEX_W = 15;

   // Q30 constants for the angle and series arithmetic
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [29:0] PI4_Q30 = 30'd843314857;

   // Divider geometry: octant split, residual angle and texture coordinate
   localparam int OCT_NW = 12;
   localparam int OCT_QW = 4;
   localparam int ANG_NW = 39;
   localparam int ANG_QW = 30;
   localparam int TEX_NW = 23;
   localparam int TEX_QW = 15;

   // Reciprocals for the constant divisors of the series: floor(v/d) equals
   // (v*M) >> K for every v below 2^30 when K = 30 + ceil(log2 d).
   localparam int K72 = 37;
   localparam int K42 = 36;
   localparam int K20 = 35;
   localparam int K6  = 33;
   localparam int K90 = 37;
   localparam int K56 = 36;
   localparam int K30 = 35;
   localparam int K12 = 34;
   localparam logic [30:0] M72 = 31'(((64'd1 << K72) + 64'd71) / 64'd72);
   localparam logic [30:0] M42 = 31'(((64'd1 << K42) + 64'd41) / 64'd42);
   localparam logic [30:0] M20 = 31'(((64'd1 << K20) + 64'd19) / 64'd20);
   localparam logic [30:0] M6  = 31'(((64'd1 << K6) + 64'd5) / 64'd6);
   localparam logic [30:0] M90 = 31'(((64'd1 << K90) + 64'd89) / 64'd90);
   localparam logic [30:0] M56 = 31'(((64'd1 << K56) + 64'd55) / 64'd56);
   localparam logic [30:0] M30 = 31'(((64'd1 << K30) + 64'd29) / 64'd30);
   localparam logic [30:0] M12 = 31'(((64'd1 << K12) + 64'd11) / 64'd12);

   // Sine/cosine latency: octant divider, residual set-up, angle divider,
   // square, eight series stages and the octant fold.
   localparam int SC_LAT = OCT_QW + 1 + ANG_QW + 1 + 9;
   // Back-end latency up to the output register, including the product stage.
   localparam int BK_LAT = SC_LAT + 1;
   // Tap of the side line that feeds the texture dividers so they finish in step.
   localparam int TEX_TAP = BK_LAT - 1 - TEX_QW;

   typedef struct packed {
      logic [8:0]       prec;
      logic [8:0]       ring;
      logic [8:0]       seg;
      logic             pole;
      logic             quad;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] c_next;
      logic [IDX_W-1:0] c_above;
      logic [IDX_W-1:0] c_diag;
   } uvs_entry_type;

   typedef struct packed {
      logic [15:0]      pos_x;
      logic [15:0]      pos_y;
      logic [15:0]      pos_z;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
      logic [15:0]      tangent_x;
      logic [15:0]      tangent_z;
      logic [IDX_W-1:0] vertex_index;
      logic             quad_valid;
      logic [IDX_W-1:0] corner_next;
      logic [IDX_W-1:0] corner_above;
      logic [IDX_W-1:0] corner_diag;
   } uvs_result_type;

endpackage

FILE: rtl/uvs_front.sv
// Front end: precision register, clamping, pole and quad classification, indices.
module uvs_front import uvs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [8:0]    csr_wr_data,
   input  logic [8:0]    ring,
   input  logic [8:0]    segment,
   output uvs_entry_type entry
);

   logic [8:0]       precision_ff;
   logic [8:0]       prec;
   logic [9:0]       prec1;
   logic [8:0]       ring_c;
   logic [8:0]       seg_c;
   logic [IDX_W-1:0] idx;
   logic             quad;

   always_ff @(posedge clock) begin
      if (reset) begin
         precision_ff <= PREC_RESET;
      end else if (csr_wr_en) begin
         precision_ff <= csr_wr_data;
      end
   end

   always_comb begin
      priority if (precision_ff == 9'd0) begin
         prec = 9'd1;
      end else if (precision_ff > MAX_PRECISION) begin
         prec = MAX_PRECISION;
      end else begin
         prec = precision_ff;
      end
      prec1  = 10'(prec) + 10'd1;
      ring_c = (ring > prec) ? prec : ring;
      seg_c  = (segment > prec) ? prec : segment;
      idx    = 17'(17'(ring_c) * 17'(prec1)) + 17'(seg_c);
      quad   = (ring_c < prec) && (seg_c < prec);

      entry.prec    = prec;
      entry.ring    = ring_c;
      entry.seg     = seg_c;
      entry.pole    = (ring_c == 9'd0) || (ring_c == prec);
      entry.quad    = quad;
      entry.idx     = idx;
      entry.c_next  = quad ? idx + 17'd1 : '0;
      entry.c_above = quad ? idx + 17'(prec1) : '0;
      entry.c_diag  = quad ? idx + 17'(prec1) + 17'd1 : '0;
   end

endmodule

FILE: rtl/uvs_queue.sv
// Short queue of classified items between the front and the back end.
module uvs_queue import uvs_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  uvs_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output uvs_entry_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   uvs_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/uvs_divider.sv
// Pipelined restoring divider, one quotient bit per stage, quotient known to fit Q_W bits.
module uvs_divider #(
   parameter int N_W = 12,
   parameter int D_W = 10,
   parameter int Q_W = 4
) (
   input  logic           clock,
   input  logic           en,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic [Q_W-1:0] quo,
   output logic [D_W-1:0] rem,
   output logic [D_W-1:0] den_out
);

   logic [D_W-1:0] rem_ff  [Q_W];
   logic [Q_W-1:0] low_ff  [Q_W];
   logic [Q_W-1:0] quo_ff  [Q_W];
   logic [D_W-1:0] den_ff  [Q_W];
   logic [D_W-1:0] rem_src [Q_W];
   logic [Q_W-1:0] low_src [Q_W];
   logic [Q_W-1:0] quo_src [Q_W];
   logic [D_W-1:0] den_src [Q_W];
   logic [D_W-1:0] rem_in  [Q_W];
   logic [Q_W-1:0] low_in  [Q_W];
   logic [Q_W-1:0] quo_in  [Q_W];
   logic [D_W:0]   trial;
   logic           take;

   // The upper part of the dividend is already below the divisor, so only
   // the low Q_W bits need to be shifted in.
   always_comb begin
      rem_src[0] = D_W'(num >> Q_W);
      low_src[0] = num[Q_W-1:0];
      quo_src[0] = '0;
      den_src[0] = den;
      for (int k = 1; k < Q_W; k++) begin
         rem_src[k] = rem_ff[k-1];
         low_src[k] = low_ff[k-1];
         quo_src[k] = quo_ff[k-1];
         den_src[k] = den_ff[k-1];
      end
      for (int k = 0; k < Q_W; k++) begin
         trial     = {rem_src[k], low_src[k][Q_W-1]};
         take      = (trial >= {1'b0, den_src[k]});
         rem_in[k] = take ? D_W'(trial - {1'b0, den_src[k]}) : trial[D_W-1:0];
         low_in[k] = low_src[k] << 1;
         quo_in[k] = Q_W'({quo_src[k], take});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         quo_ff <= quo_in;
         den_ff <= den_src;
      end
   end

   assign quo     = quo_ff[Q_W-1];
   assign rem     = rem_ff[Q_W-1];
   assign den_out = den_ff[Q_W-1];

endmodule

FILE: rtl/uvs_sincos.sv
// Pipelined sine and cosine of num/den of a full turn, as Q30 magnitudes and signs.
module uvs_sincos import uvs_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [8:0]       num,
   input  logic [DEN_W-1:0] den,
   output logic [30:0]      sin_mag,
   output logic             sin_neg,
   output logic [30:0]      cos_mag,
   output logic             cos_neg
);

   function automatic logic [29:0] q30_mul(input logic [29:0] a, input logic [30:0] b);
      logic [60:0] prod;
      prod = 61'(a) * 61'(b);
      return prod[59:30];
   endfunction

   logic [OCT_QW-1:0] oct_quo;
   logic [DEN_W-1:0]  oct_rem;
   logic [DEN_W-1:0]  oct_den;
   logic [2:0]        oct_b;
   logic [DEN_W-1:0]  resid;
   logic [39:0]       scaled;
   logic [2:0]        oct_b_ff;
   logic [ANG_NW-1:0] dvd_ff;
   logic [DEN_W-1:0]  den_b_ff;
   logic [ANG_QW-1:0] ang;
   logic [2:0]        oct_dl_ff [ANG_QW];
   logic [59:0]       sq;
   logic [29:0]       x2_ff [8];
   logic [29:0]       x_ff  [8];
   logic [2:0]        oct_ff [9];
   logic [60:0]       s1_ff, s3_ff, s5_ff, s7_ff;
   logic [60:0]       c1_ff, c3_ff, c5_ff, c7_ff;
   logic [29:0]       s2_ff, s4_ff, s6_ff, s8_ff;
   logic [29:0]       c2_ff, c4_ff, c6_ff, c8_ff;
   logic [30:0]       s_fin;
   logic [30:0]       c_fin;
   logic [2:0]        oct_fin;
   logic [30:0]       sin_mag_ff, cos_mag_ff;
   logic              sin_neg_ff, cos_neg_ff;

   // Octant and remainder of 8*num/den.
   uvs_divider #(.N_W(OCT_NW), .D_W(DEN_W), .Q_W(OCT_QW)) u_oct (
      .clock   (clock),
      .en      (en),
      .num     ({num, 3'b000}),
      .den     (den),
      .quo     (oct_quo),
      .rem     (oct_rem),
      .den_out (oct_den)
   );

   // Odd octants measure the residual from the far edge.
   always_comb begin
      oct_b  = oct_quo[2:0];
      resid  = oct_b[0] ? oct_den - oct_rem : oct_rem;
      scaled = {30'd0, resid} * {10'd0, PI4_Q30};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         oct_b_ff <= oct_b;
         dvd_ff   <= ANG_NW'(scaled + 40'(oct_den >> 1));
         den_b_ff <= oct_den;
      end
   end

   // Residual angle in Q30 radians, rounded.
   uvs_divider #(.N_W(ANG_NW), .D_W(DEN_W), .Q_W(ANG_QW)) u_ang (
      .clock   (clock),
      .en      (en),
      .num     (dvd_ff),
      .den     (den_b_ff),
      .quo     (ang),
      .rem     (),
      .den_out ()
   );

   assign sq = 60'(ang) * 60'(ang);

   always_ff @(posedge clock) begin
      if (en) begin
         oct_dl_ff[0] <= oct_b_ff;
         for (int k = 1; k < ANG_QW; k++) begin
            oct_dl_ff[k] <= oct_dl_ff[k-1];
         end
         x2_ff[0]  <= sq[59:30];
         x_ff[0]   <= ang;
         oct_ff[0] <= oct_dl_ff[ANG_QW-1];
         for (int k = 1; k < 8; k++) begin
            x2_ff[k] <= x2_ff[k-1];
            x_ff[k]  <= x_ff[k-1];
         end
         for (int k = 1; k < 9; k++) begin
            oct_ff[k] <= oct_ff[k-1];
         end
      end
   end

   // Horner evaluation of both series, a reciprocal multiply and a Q30
   // multiply in alternate stages.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= 61'(x2_ff[0]) * 61'(M72);
         c1_ff <= 61'(x2_ff[0]) * 61'(M90);
         s2_ff <= q30_mul(x2_ff[1], Q30_ONE - 31'(s1_ff >> K72));
         c2_ff <= q30_mul(x2_ff[1], Q30_ONE - 31'(c1_ff >> K90));
         s3_ff <= 61'(s2_ff) * 61'(M42);
         c3_ff <= 61'(c2_ff) * 61'(M56);
         s4_ff <= q30_mul(x2_ff[3], Q30_ONE - 31'(s3_ff >> K42));
         c4_ff <= q30_mul(x2_ff[3], Q30_ONE - 31'(c3_ff >> K56));
         s5_ff <= 61'(s4_ff) * 61'(M20);
         c5_ff <= 61'(c4_ff) * 61'(M30);
         s6_ff <= q30_mul(x2_ff[5], Q30_ONE - 31'(s5_ff >> K20));
         c6_ff <= q30_mul(x2_ff[5], Q30_ONE - 31'(c5_ff >> K30));
         s7_ff <= 61'(s6_ff) * 61'(M6);
         c7_ff <= 61'(c6_ff) * 61'(M12);
         s8_ff <= q30_mul(x_ff[7], Q30_ONE - 31'(s7_ff >> K6));
         c8_ff <= q30_mul(x2_ff[7], Q30_ONE - 31'(c7_ff >> K12));
      end
   end

   // Octant fold: octants 1, 2, 5 and 6 swap sine and cosine.
   always_comb begin
      s_fin   = 31'(s8_ff);
      c_fin   = Q30_ONE - 31'(c8_ff >> 1);
      oct_fin = oct_ff[8];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_mag_ff <= (oct_fin[1] ^ oct_fin[0]) ? c_fin : s_fin;
         cos_mag_ff <= (oct_fin[1] ^ oct_fin[0]) ? s_fin : c_fin;
         sin_neg_ff <= oct_fin[2];
         cos_neg_ff <= oct_fin[2] ^ oct_fin[1];
      end
   end

   assign sin_mag = sin_mag_ff;
   assign sin_neg = sin_neg_ff;
   assign cos_mag = cos_mag_ff;
   assign cos_neg = cos_neg_ff;

endmodule

FILE: rtl/uvs_back.sv
// Back end: trigonometry, texture division, products, rounding and the output register.
module uvs_back import uvs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  uvs_entry_type  head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output uvs_result_type rsp
);

   localparam int YSH = 30 - COORD_FRAC_BITS;
   localparam int PSH = 60 - COORD_FRAC_BITS;

   logic           en;
   logic           v_ff  [BK_LAT];
   uvs_entry_type  sd_ff [BK_LAT];
   uvs_entry_type  last;
   logic [30:0]    rs_mag, rc_mag, ss_mag, sc_mag;
   logic           rs_neg, rc_neg, ss_neg, sc_neg;
   logic [61:0]    xprod_ff, zprod_ff;
   logic [30:0]    ymag_ff;
   logic           xneg_ff, yneg_ff, zneg_ff;
   logic [TEX_NW-1:0] u_num, v_num;
   logic [TEX_QW-1:0] u_quo, v_quo;
   logic [31:0]    ysum;
   logic [62:0]    xsum, zsum;
   logic [15:0]    xmag, ymag, zmag;
   logic [15:0]    pos_x, pos_z;
   uvs_result_type res;
   logic           rsp_valid_ff;
   uvs_result_type rsp_ff;

   // The whole back end advances together; the output register frees it.
   assign en  = !rsp_valid_ff || rsp_ready;
   assign pop = en && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < BK_LAT; k++) begin
            v_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= head_valid;
         for (int k = 1; k < BK_LAT; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         rsp_valid_ff <= v_ff[BK_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= head;
         for (int k = 1; k < BK_LAT; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   uvs_sincos u_ring (
      .clock   (clock),
      .en      (en),
      .num     (head.ring),
      .den     ({head.prec, 1'b0}),
      .sin_mag (rs_mag),
      .sin_neg (rs_neg),
      .cos_mag (rc_mag),
      .cos_neg (rc_neg)
   );

   uvs_sincos u_seg (
      .clock   (clock),
      .en      (en),
      .num     (head.seg),
      .den     ({1'b0, head.prec}),
      .sin_mag (ss_mag),
      .sin_neg (ss_neg),
      .cos_mag (sc_mag),
      .cos_neg (sc_neg)
   );

   // The ring sine is a radius and never negative, so its sign is not used.
   always_ff @(posedge clock) begin
      if (en) begin
         xprod_ff <= 62'(sc_mag) * 62'(rs_mag);
         zprod_ff <= 62'(ss_mag) * 62'(rs_mag);
         ymag_ff  <= rc_mag;
         xneg_ff  <= !sc_neg;
         yneg_ff  <= !rc_neg;
         zneg_ff  <= ss_neg ^ (rs_neg & 1'b0);
      end
   end

   // Texture coordinates start late enough to finish with the products.
   assign u_num = (TEX_NW'(sd_ff[TEX_TAP].seg) << COORD_FRAC_BITS)
                  + TEX_NW'(sd_ff[TEX_TAP].prec >> 1);
   assign v_num = (TEX_NW'(sd_ff[TEX_TAP].ring) << COORD_FRAC_BITS)
                  + TEX_NW'(sd_ff[TEX_TAP].prec >> 1);

   uvs_divider #(.N_W(TEX_NW), .D_W(9), .Q_W(TEX_QW)) u_tex_u (
      .clock   (clock),
      .en      (en),
      .num     (u_num),
      .den     (sd_ff[TEX_TAP].prec),
      .quo     (u_quo),
      .rem     (),
      .den_out ()
   );

   uvs_divider #(.N_W(TEX_NW), .D_W(9), .Q_W(TEX_QW)) u_tex_v (
      .clock   (clock),
      .en      (en),
      .num     (v_num),
      .den     (sd_ff[TEX_TAP].prec),
      .quo     (v_quo),
      .rem     (),
      .den_out ()
   );

   // Rounding is applied to the magnitude and the sign afterwards.
   always_comb begin
      last  = sd_ff[BK_LAT-1];
      ysum  = 32'(ymag_ff) + (32'd1 << (YSH - 1));
      xsum  = 63'(xprod_ff) + (63'd1 << (PSH - 1));
      zsum  = 63'(zprod_ff) + (63'd1 << (PSH - 1));
      ymag  = 16'(ysum >> YSH);
      xmag  = 16'(xsum >> PSH);
      zmag  = 16'(zsum >> PSH);
      pos_x = xneg_ff ? 16'd0 - xmag : xmag;
      pos_z = zneg_ff ? 16'd0 - zmag : zmag;

      res.pos_x        = pos_x;
      res.pos_y        = yneg_ff ? 16'd0 - ymag : ymag;
      res.pos_z        = pos_z;
      res.tex_u        = u_quo;
      res.tex_v        = v_quo;
      res.tangent_x    = last.pole ? 16'd0 : pos_z;
      res.tangent_z    = last.pole ? 16'd0 - (16'd1 << COORD_FRAC_BITS)
                                   : (xneg_ff ? xmag : 16'd0 - xmag);
      res.vertex_index = last.idx;
      res.quad_valid   = last.quad;
      res.corner_next  = last.c_next;
      res.corner_above = last.c_above;
      res.corner_diag  = last.c_diag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/uv_sphere_vertex_generator.sv
// UV sphere vertex generator: each accepted item (ring, segment) yields one result item
// with the Q2.14 position, texture coordinates and tangent of that grid point, its flat
// vertex index and, when it starts a quad, the other corner indices. While the output
// side does not stall, the block accepts one item per cycle and returns one result per
// cycle. Most of the pipeline is the 30 one-bit stages of the restoring divider that
// forms the residual angle, followed by the series evaluation in the sine/cosine
// pipelines. A four-entry queue separates the input side from the computing pipeline,
// so input is still taken while a result waits.
module uv_sphere_vertex_generator import uvs_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [8:0]   csr_wr_data,    // precision
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,      // ring[8:0], segment[17:9], zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, tangent_x, tangent_z, vertex_index,
   // corner_next, corner_above, corner_diag, zero fill
   output logic [183:0] rsp_tdata,
   output logic         rsp_tuser       // quad_valid
);

   uvs_entry_type  entry;
   uvs_entry_type  head;
   logic           full;
   logic           head_valid;
   logic           pop;
   uvs_result_type res;

   uvs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ring        (req_tdata[8:0]),
      .segment     (req_tdata[17:9]),
      .entry       (entry)
   );

   assign req_tready = !full;

   uvs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_data  (entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   uvs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (res)
   );

   assign rsp_tdata = {6'd0, res.corner_diag, res.corner_above, res.corner_next,
                       res.vertex_index, res.tangent_z, res.tangent_x, res.tex_v,
                       res.tex_u, res.pos_z, res.pos_y, res.pos_x};
   assign rsp_tuser = res.quad_valid;

endmodule

FILE: rtl/uvs_checker.sv
// Port-level checks for the UV sphere vertex generator, bound to the top level.
module uvs_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [183:0] rsp_tdata,
   input logic         rsp_tuser
);

   // A waiting result item keeps its contents until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Quad corners follow from the vertex index and from each other.
   a_quad_corners: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[143:127] == rsp_tdata[126:110] + 17'd1) &&
         (rsp_tdata[177:161] == rsp_tdata[160:144] + 17'd1))
      else $error("quad corner indices inconsistent");

   a_no_quad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[177:127] == 51'd0)
      else $error("corners not cleared without a quad");

   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[62:48] <= 15'd16384) && (rsp_tdata[77:63] <= 15'd16384))
      else $error("texture coordinate above one");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
